FILE: design/iorrb_pkg.sv
package iorrb_pkg;

    // Queue geometry and tag counter width.
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Field widths on the stream ports.
    localparam int FIELD_W    = 32;
    localparam int TYPE_W     = 2;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = 2 * FIELD_W;
    localparam int OUT_DATA_W = 2 * FIELD_W;
    localparam int OUT_USER_W = KIND_W + 1;

    // Input item types.
    localparam logic [TYPE_W-1:0] REQ_NEW   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_REPLY = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_MSG   = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_TAG  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJ  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN
    } t_state;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_TAG,
        EMIT_MSG,
        EMIT_REJ,
        EMIT_PEND
    } t_emit_sel;

    typedef struct packed {
        logic      capture;
        logic      append_req;
        logic      append_msg;
        logic      reply_upd;
        logic      pend_load;
        t_emit_sel emit;
        logic      emit_last;
    } t_cmd;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic              link_up;
        logic              empty;
        logic              full;
        logic              out_free;
        logic              nonhead_hit;
        logic              head_avail;
        logic              pend_valid;
    } t_status;

    // Circular index wrap for a value below twice the depth.
    function automatic logic [IDX_W-1:0] f_wrap(input logic [IDX_W:0] v);
        logic [IDX_W:0] d;
        d = (IDX_W+1)'(QUEUE_DEPTH);
        if (v >= d) begin
            return IDX_W'(v - d);
        end
        return IDX_W'(v);
    endfunction

endpackage

FILE: design/in_order_reply_reorder_buffer.sv
// A tag, rejection or message result is loaded into the output register in the execution
// state after its input transfer is captured, once that register is free; a drained entry
// first passes the holding register. Each item is captured and executed before the next is
// taken; a reply, unless it completes an entry behind the head or the link is down, then drains
// one result per cycle while the output is free, as set by the single head read of the store.
// Reset is synchronous and active low; it empties the queue, zeroes the tag counter and sets
// link_up. Entry contents are not cleared and need no clearing pass.
module in_order_reply_reorder_buffer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [iorrb_pkg::IN_DATA_W-1:0]     i_s_tdata,  // request_tag, payload_tag
    input  logic [iorrb_pkg::TYPE_W-1:0]        i_s_tuser,  // req_type
    // Result stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [iorrb_pkg::OUT_DATA_W-1:0]    o_m_tdata,  // tag_out, payload_out
    output logic [iorrb_pkg::OUT_USER_W-1:0]    o_m_tuser,  // result_kind, is_reply
    output logic                                o_m_tlast,  // last
    // Configuration write channel for link_up.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data
);
    import iorrb_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // The link_up register takes every write transfer at once.
    assign o_cfg_ready = 1'b1;

    // The controller sequences each item: capture (the reply tag is compared with
    // every live entry in the same cycle), execution, and for a reply with the link
    // up and no match behind the head a drain that moves one entry a cycle, while the
    // output is free, into a holding register. The held entry is sent once the next
    // head is known, so that the last marker can be set on the final drain result.
    iorrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the entry store, queue pointers, tag counter and the output
    // register. A finished result waits there while the next item is taken in.
    iorrb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_type      (i_s_tuser),
        .i_rtag      (i_s_tdata[FIELD_W-1:0]),
        .i_pay       (i_s_tdata[2*FIELD_W-1:FIELD_W]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_status    (w_status),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

FILE: design/iorrb_ctrl.sv
module iorrb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  iorrb_pkg::t_status i_status,
    output logic               o_s_tready,
    output iorrb_pkg::t_cmd    o_cmd
);
    import iorrb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_status.req_type)
                    REQ_NEW: begin
                        if (i_status.out_free) begin
                            n_state = ST_IDLE;
                        end
                    end
                    REQ_REPLY: begin
                        if (!i_status.link_up || i_status.nonhead_hit) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_DRAIN;
                        end
                    end
                    REQ_MSG: begin
                        if (!i_status.link_up) begin
                            n_state = ST_IDLE;
                        end else if (i_status.empty || i_status.full) begin
                            if (i_status.out_free) begin
                                n_state = ST_IDLE;
                            end
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_DRAIN: begin
                if (!i_status.head_avail) begin
                    if (!i_status.pend_valid || i_status.out_free) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            ST_EXEC: begin
                case (i_status.req_type)
                    REQ_NEW: begin
                        if (i_status.out_free) begin
                            if (i_status.full) begin
                                o_cmd.emit = EMIT_REJ;
                            end else begin
                                o_cmd.append_req = 1'b1;
                                o_cmd.emit       = EMIT_TAG;
                            end
                        end
                    end
                    REQ_REPLY: begin
                        o_cmd.reply_upd = i_status.link_up;
                    end
                    REQ_MSG: begin
                        if (i_status.link_up) begin
                            if (i_status.empty) begin
                                if (i_status.out_free) begin
                                    o_cmd.emit = EMIT_MSG;
                                end
                            end else if (i_status.full) begin
                                if (i_status.out_free) begin
                                    o_cmd.emit = EMIT_REJ;
                                end
                            end else begin
                                o_cmd.append_msg = 1'b1;
                            end
                        end
                    end
                    default: begin
                        o_cmd = '0;
                    end
                endcase
            end
            ST_DRAIN: begin
                if (i_status.head_avail) begin
                    if (!i_status.pend_valid) begin
                        o_cmd.pend_load = 1'b1;
                    end else if (i_status.out_free) begin
                        o_cmd.pend_load = 1'b1;
                        o_cmd.emit      = EMIT_PEND;
                    end
                end else if (i_status.pend_valid && i_status.out_free) begin
                    o_cmd.emit      = EMIT_PEND;
                    o_cmd.emit_last = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/iorrb_dp.sv
module iorrb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  iorrb_pkg::t_cmd                     i_cmd,
    input  logic [iorrb_pkg::TYPE_W-1:0]        i_type,
    input  logic [iorrb_pkg::FIELD_W-1:0]       i_rtag,
    input  logic [iorrb_pkg::FIELD_W-1:0]       i_pay,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_data,
    input  logic                                i_m_tready,
    output iorrb_pkg::t_status                  o_status,
    output logic                                o_m_tvalid,
    output logic [iorrb_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic [iorrb_pkg::OUT_USER_W-1:0]    o_m_tuser,
    output logic                                o_m_tlast
);
    import iorrb_pkg::*;

    // Entry store.
    logic                r_has_tag [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] r_tag     [QUEUE_DEPTH];
    logic                r_done    [QUEUE_DEPTH];
    logic [FIELD_W-1:0]  r_pay_ent [QUEUE_DEPTH];

    // Queue control.
    logic                r_link_up;
    logic [TAG_BITS-1:0] r_next_tag;
    logic [IDX_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_count;

    // Captured item.
    logic [TYPE_W-1:0]      r_type;
    logic [FIELD_W-1:0]     r_pay;
    logic [QUEUE_DEPTH-1:0] r_match;

    // Entry held back until it is known whether it closes the drain.
    logic               r_pend_valid;
    logic [FIELD_W-1:0] r_pend_tag;
    logic [FIELD_W-1:0] r_pend_pay;
    logic               r_pend_rep;

    // Output register.
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [FIELD_W-1:0] r_out_tag;
    logic [FIELD_W-1:0] r_out_pay;
    logic               r_out_rep;
    logic               r_out_last;

    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_rot;
    logic [IDX_W-1:0]       w_off;
    logic [IDX_W-1:0]       w_nh_pos;
    logic [IDX_W-1:0]       w_nh_slot;
    logic                   w_nh_hit;
    logic                   w_head_match;
    logic [IDX_W-1:0]       w_tail;
    logic [IDX_W-1:0]       w_head_nxt;
    logic                   w_append;
    logic                   w_out_free;

    // Compare the incoming reply tag with every live entry.
    always_comb begin
        w_match = '0;
        w_off   = '0;
        for (int s = 0; s < QUEUE_DEPTH; s++) begin
            w_off = f_wrap((IDX_W+1)'(s) + (IDX_W+1)'(QUEUE_DEPTH) - {1'b0, r_head});
            w_match[s] = ({1'b0, w_off} < r_count) && r_has_tag[s]
                         && (64'(r_tag[s]) == 64'(i_rtag));
        end
    end

    // Matches in queue order, and the first match behind the head.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_rot[i] = r_match[f_wrap({1'b0, r_head} + (IDX_W+1)'(i))];
        end
        w_nh_hit = |w_rot[QUEUE_DEPTH-1:1];
        w_nh_pos = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 1; i--) begin
            if (w_rot[i]) begin
                w_nh_pos = IDX_W'(i);
            end
        end
    end

    assign w_nh_slot    = f_wrap({1'b0, r_head} + {1'b0, w_nh_pos});
    assign w_head_match = r_match[r_head];
    assign w_tail       = f_wrap({1'b0, r_head} + r_count[IDX_W:0]);
    assign w_head_nxt   = f_wrap({1'b0, r_head} + (IDX_W+1)'(1));
    assign w_append     = i_cmd.append_req || i_cmd.append_msg;
    assign w_out_free   = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < QUEUE_DEPTH; s++) begin
            if (w_append && (w_tail == IDX_W'(s))) begin
                r_has_tag[s] <= i_cmd.append_req;
                r_tag[s]     <= r_next_tag;
                r_done[s]    <= i_cmd.append_msg;
                r_pay_ent[s] <= i_cmd.append_msg ? r_pay : '0;
            end else if (i_cmd.reply_upd
                         && ((w_head_match && (r_head == IDX_W'(s)))
                             || (w_nh_hit && (w_nh_slot == IDX_W'(s))))) begin
                r_done[s]    <= 1'b1;
                r_pay_ent[s] <= r_pay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_up  <= 1'b1;
            r_next_tag <= '0;
            r_head     <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_link_up <= i_cfg_data;
            end
            if (i_cmd.append_req) begin
                r_next_tag <= r_next_tag + TAG_BITS'(1);
            end
            if (w_append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pend_load) begin
                r_count <= r_count - CNT_W'(1);
                r_head  <= w_head_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type  <= i_type;
            r_pay   <= i_pay;
            r_match <= w_match;
        end
        if (i_cmd.pend_load) begin
            r_pend_tag <= r_has_tag[r_head] ? FIELD_W'(r_tag[r_head]) : '0;
            r_pend_pay <= r_pay_ent[r_head];
            r_pend_rep <= r_has_tag[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.pend_load) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.emit == EMIT_PEND) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.emit != EMIT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EMIT_TAG: begin
                r_out_kind <= KIND_TAG;
                r_out_tag  <= FIELD_W'(r_next_tag);
                r_out_pay  <= '0;
                r_out_rep  <= 1'b0;
                r_out_last <= 1'b1;
            end
            EMIT_MSG: begin
                r_out_kind <= KIND_SENT;
                r_out_tag  <= '0;
                r_out_pay  <= r_pay;
                r_out_rep  <= 1'b0;
                r_out_last <= 1'b1;
            end
            EMIT_REJ: begin
                r_out_kind <= KIND_REJ;
                r_out_tag  <= '0;
                r_out_pay  <= '0;
                r_out_rep  <= 1'b0;
                r_out_last <= 1'b1;
            end
            EMIT_PEND: begin
                r_out_kind <= KIND_SENT;
                r_out_tag  <= r_pend_tag;
                r_out_pay  <= r_pend_pay;
                r_out_rep  <= r_pend_rep;
                r_out_last <= i_cmd.emit_last;
            end
            default: begin
                r_out_kind <= r_out_kind;
            end
        endcase
    end

    assign o_status.req_type    = r_type;
    assign o_status.link_up     = r_link_up;
    assign o_status.empty       = (r_count == '0);
    assign o_status.full        = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.out_free    = w_out_free;
    assign o_status.nonhead_hit = w_nh_hit;
    assign o_status.head_avail  = (r_count != '0) && r_done[r_head];
    assign o_status.pend_valid  = r_pend_valid;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_pay, r_out_tag};
    assign o_m_tuser  = {r_out_rep, r_out_kind};
    assign o_m_tlast  = r_out_last;

endmodule

FILE: bench/tb_in_order_reply_reorder_buffer.sv
module tb_in_order_reply_reorder_buffer;
    import iorrb_pkg::*;

    // The fourth encoding of the item type carries no meaning and must be ignored.
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    // At most this many completed entries leave the queue in answer to one transfer.
    localparam int MAX_SENT = 16;
    // Cycles allowed for a transfer that yields no result to clear the block.
    localparam int SETTLE_CYCLES = 12;
    // Cycles at the end before the run is given up as hung.
    localparam int TIMEOUT_CYCLES = 200000;

    typedef struct {
        logic [TYPE_W-1:0]  req_type;
        logic [FIELD_W-1:0] request_tag;
        logic [FIELD_W-1:0] payload_tag;
    } t_link_item;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] tag;
        logic [FIELD_W-1:0] payload;
        logic               is_reply;
        logic               last;
    } t_link_result;

    // Every input of the block has a known value from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;   // request_tag, payload_tag
    logic [TYPE_W-1:0]     i_s_tuser   = '0;   // req_type
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;          // tag_out, payload_out
    logic [OUT_USER_W-1:0] o_m_tuser;          // result_kind, is_reply
    logic                  o_m_tlast;          // last
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_data  = 1'b0;

    in_order_reply_reorder_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Items waiting to be offered, and results that the shadow queue says must follow.
    t_link_item   pending_items   [$];
    t_link_result awaited_results [$];
    t_link_item   offer;

    // Idling knobs, in percent of cycles, and the long receiver hold-off in cycles.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_left          = 0;
    int error_count        = 0;

    // Shadow copy of the link register and of the reorder queue, updated on each
    // accepted transfer.
    logic                link_up_q    = 1'b1;
    logic [TAG_BITS-1:0] tag_counter  = '0;
    int unsigned         head_slot    = 0;
    int unsigned         held_count   = 0;
    logic                slot_has_tag [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] slot_tag     [QUEUE_DEPTH];
    logic                slot_done    [QUEUE_DEPTH];
    logic [FIELD_W-1:0]  slot_payload [QUEUE_DEPTH];

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Storage slot of the entry that stands at the given position behind the head.
    function automatic int unsigned slot_of(input int unsigned pos);
        return (head_slot + pos) % QUEUE_DEPTH;
    endfunction

    task automatic expect_result(input logic [KIND_W-1:0] kind, input logic [FIELD_W-1:0] tag,
                                 input logic [FIELD_W-1:0] payload, input logic is_reply,
                                 input logic last);
        t_link_result r;
        r.kind     = kind;
        r.tag      = tag;
        r.payload  = payload;
        r.is_reply = is_reply;
        r.last     = last;
        awaited_results.push_back(r);
    endtask

    task automatic hold_entry(input logic has_tag, input logic [TAG_BITS-1:0] tag,
                              input logic done, input logic [FIELD_W-1:0] payload);
        int unsigned s;
        s = slot_of(held_count);
        slot_has_tag[s] = has_tag;
        slot_tag[s]     = tag;
        slot_done[s]    = done;
        slot_payload[s] = payload;
        held_count++;
    endtask

    // Sends every completed entry at the front of the queue, up to the per-transfer cap.
    // The last marker goes on the final entry sent; when nothing leaves, nothing is expected.
    task automatic send_completed_front();
        int unsigned s;
        int          sent;
        logic        more;
        sent = 0;
        while (held_count > 0 && sent < MAX_SENT && slot_done[slot_of(0)]) begin
            s          = slot_of(0);
            head_slot  = (head_slot + 1) % QUEUE_DEPTH;
            held_count--;
            sent++;
            more = held_count > 0 && sent < MAX_SENT && slot_done[slot_of(0)];
            expect_result(KIND_SENT, slot_has_tag[s] ? slot_tag[s] : {FIELD_W{1'b0}},
                          slot_payload[s], slot_has_tag[s], !more);
        end
    endtask

    // Works out the results of one accepted item and moves the shadow queue on.
    task automatic predict_reorder(input t_link_item it);
        int unsigned s;
        case (it.req_type)
            REQ_NEW: begin
                if (held_count >= QUEUE_DEPTH) begin
                    expect_result(KIND_REJ, '0, '0, 1'b0, 1'b1);
                end else begin
                    expect_result(KIND_TAG, tag_counter, '0, 1'b0, 1'b1);
                    hold_entry(1'b1, tag_counter, 1'b0, '0);
                    tag_counter = tag_counter + 1'b1;
                end
            end
            REQ_REPLY: begin
                if (!link_up_q) begin
                    return;
                end
                // The head and the first request entry behind it with the tag take the payload.
                // A match behind the head stops the search and leaves the queue where it is.
                for (int unsigned i = 0; i < held_count; i++) begin
                    s = slot_of(i);
                    if (slot_has_tag[s] && slot_tag[s] == it.request_tag) begin
                        slot_done[s]    = 1'b1;
                        slot_payload[s] = it.payload_tag;
                        if (i != 0) begin
                            return;
                        end
                    end
                end
                send_completed_front();
            end
            REQ_MSG: begin
                if (!link_up_q) begin
                    return;
                end
                if (held_count == 0) begin
                    expect_result(KIND_SENT, '0, it.payload_tag, 1'b0, 1'b1);
                end else if (held_count >= QUEUE_DEPTH) begin
                    expect_result(KIND_REJ, '0, '0, 1'b0, 1'b1);
                end else begin
                    hold_entry(1'b0, '0, 1'b1, it.payload_tag);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result();
        t_link_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result: kind %0d tag %h payload %h",
                                      o_m_tuser[KIND_W-1:0], o_m_tdata[FIELD_W-1:0],
                                      o_m_tdata[2*FIELD_W-1:FIELD_W]));
            return;
        end
        want = awaited_results.pop_front();
        if (o_m_tuser[KIND_W-1:0] !== want.kind) begin
            report_mismatch($sformatf("result_kind %0d, expected %0d",
                                      o_m_tuser[KIND_W-1:0], want.kind));
        end
        if (o_m_tdata[FIELD_W-1:0] !== want.tag) begin
            report_mismatch($sformatf("tag_out %h, expected %h",
                                      o_m_tdata[FIELD_W-1:0], want.tag));
        end
        if (o_m_tdata[2*FIELD_W-1:FIELD_W] !== want.payload) begin
            report_mismatch($sformatf("payload_out %h, expected %h",
                                      o_m_tdata[2*FIELD_W-1:FIELD_W], want.payload));
        end
        if (o_m_tuser[KIND_W] !== want.is_reply) begin
            report_mismatch($sformatf("is_reply %b, expected %b",
                                      o_m_tuser[KIND_W], want.is_reply));
        end
        if (o_m_tlast !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b", o_m_tlast, want.last));
        end
    endtask

    // Monitor. Results are checked before the item accepted at the same edge is predicted;
    // a result is registered only after its item's execution, so the two never belong together.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                check_result();
            end
            if (i_s_tvalid && o_s_tready) begin
                predict_reorder('{i_s_tuser, i_s_tdata[FIELD_W-1:0],
                                  i_s_tdata[2*FIELD_W-1:FIELD_W]});
            end
            if (i_cfg_valid && o_cfg_ready) begin
                link_up_q = i_cfg_data;
            end
        end
    end

    // Driver. A new item is put up only once the previous transfer has completed, so
    // tvalid never drops while an item is on offer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                offer = pending_items.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= offer.req_type;
                i_s_tdata  <= {offer.payload_tag, offer.request_tag};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver. A requested hold-off is counted down here with tready held low; otherwise
    // tready follows the stall percentage.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic push_item(input logic [TYPE_W-1:0] req_type,
                             input logic [FIELD_W-1:0] request_tag,
                             input logic [FIELD_W-1:0] payload_tag);
        pending_items.push_back('{req_type, request_tag, payload_tag});
    endtask

    // Random item shaped by the shadow queue: most replies name a tag that is really
    // held, with the head favoured so that drains happen often; the rest name a tag
    // not yet issued or a fully random one. A nearly full queue shifts the mix to replies.
    function automatic t_link_item next_random_item();
        t_link_item  it;
        int          pick;
        int          reply_pct;
        int unsigned lane;
        it.request_tag = $urandom();
        it.payload_tag = $urandom();
        reply_pct = (held_count >= QUEUE_DEPTH - 2) ? 70 : 45;
        pick = $urandom_range(99);
        if (pick < reply_pct) begin
            it.req_type = REQ_REPLY;
            if (held_count > 0 && $urandom_range(99) < 85) begin
                lane = ($urandom_range(99) < 40) ? 0 : $urandom_range(held_count - 1);
                it.request_tag = slot_tag[slot_of(lane)];
            end else if ($urandom_range(1) == 1) begin
                it.request_tag = tag_counter;
            end
        end else if (pick < reply_pct + 12) begin
            it.req_type = REQ_MSG;
        end else if (pick < reply_pct + 15) begin
            it.req_type = REQ_UNUSED;
        end else begin
            it.req_type = REQ_NEW;
        end
        return it;
    endfunction

    // Keeps the driver's queue short so that each new item sees an up-to-date shadow.
    // Ignored items do not count towards the total.
    task automatic queue_random_items(input int total);
        t_link_item it;
        int         made;
        made = 0;
        @(negedge i_clk);
        while (made < total) begin
            while (pending_items.size() >= 2) begin
                @(negedge i_clk);
            end
            it = next_random_item();
            pending_items.push_back(it);
            if (it.req_type != REQ_UNUSED) begin
                made++;
            end
        end
    endtask

    // Sender pause: waits until every item has been accepted and every awaited result
    // has come, then gives a transfer that yields nothing time to clear the block.
    task automatic wait_idle();
        while (pending_items.size() != 0 || i_s_tvalid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_link(input logic up);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= up;
        do begin
            @(posedge i_clk);
        end while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the link up as after reset. A message into an empty queue
        // goes straight out; the unused type and a reply to nothing are silent.
        push_item(REQ_MSG, '0, '0);
        push_item(REQ_UNUSED, '1, '1);
        push_item(REQ_REPLY, '1, '0);
        // One request and fifteen queued messages fill the queue, so the next request
        // and message are rejected, and the reply to the head sends all sixteen at once.
        push_item(REQ_NEW, '0, '0);
        repeat (15) push_item(REQ_MSG, $urandom(), $urandom());
        push_item(REQ_NEW, '1, '1);
        push_item(REQ_MSG, '0, '1);
        push_item(REQ_REPLY, 32'd0, '1);
        // Out-of-order replies: the later request is answered twice while the head waits,
        // the second payload replacing the first, then the head answer releases both.
        push_item(REQ_NEW, '0, '0);
        push_item(REQ_NEW, '0, '0);
        push_item(REQ_REPLY, 32'd2, 32'h5a5a_a5a5);
        push_item(REQ_REPLY, 32'd2, 32'ha5a5_5a5a);
        push_item(REQ_REPLY, 32'd1, 32'h0000_ffff);
        wait_idle();

        queue_random_items(25);

        // With the link down a request still takes a tag, but its reply and a message
        // are dropped.
        write_link(1'b0);
        push_item(REQ_NEW, '0, '0);
        push_item(REQ_REPLY, tag_counter, $urandom());
        push_item(REQ_MSG, '0, $urandom());
        queue_random_items(8);

        write_link(1'b1);
        sender_idle_pct = 72;
        queue_random_items(25);
        wait_idle();

        sender_idle_pct    = 0;
        receiver_stall_pct = 72;
        queue_random_items(25);

        write_link(1'b0);
        write_link(1'b1);
        sender_idle_pct    = 32;
        receiver_stall_pct = 32;
        queue_random_items(25);
        wait_idle();

        // Long receiver hold-off with the sender offering flat out, so the block backs up
        // and stalls its input transfers.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        @(negedge i_clk);
        hold_left = 120;
        queue_random_items(15);
        wait_idle();

        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

endmodule
